// ----- sv/pcr_pkg.sv -----
package pcr_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int COLOR_W = 32;
  localparam int FUNC_W  = 2;
  localparam int MATCH_W = 8;

  localparam logic [FUNC_W-1:0] FN_LOAD_KEY = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_PAL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMAP    = 2'd2;

  // pixel request travelling along the key cells
  typedef struct packed {
    logic               vld;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   idx;
    logic               found;
  } pcr_tok_t;

  // key table write, broadcast to every cell
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [COLOR_W-1:0] data;
  } pcr_kwr_t;

  function automatic logic [MATCH_W-1:0] match_bits(input logic [IDX_W-1:0] idx);
    logic [IDX_W+MATCH_W-1:0] ext;
    ext = {{MATCH_W{1'b0}}, idx};
    return ext[MATCH_W-1:0];
  endfunction

endpackage

// ----- sv/pcr_if.sv -----
interface pcr_in_if;
  import pcr_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic                table_restart;
  logic [COLOR_W-1:0]  color;

  modport source (output valid, func, table_restart, color, input ready);
  modport sink   (input valid, func, table_restart, color, output ready);
endinterface

interface pcr_out_if;
  import pcr_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  out_color;
  logic [MATCH_W-1:0]  match_index;
  logic                no_match;
  logic                palette_miss;

  modport source (output valid, out_color, match_index, no_match, palette_miss, input ready);
  modport sink   (input valid, out_color, match_index, no_match, palette_miss, output ready);
endinterface

// ----- sv/pcr_ram.sv -----
module pcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/pcr_cell.sv -----
module pcr_cell import pcr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [CNT_W-1:0] key_count,
  input  pcr_kwr_t         kwr,
  input  pcr_tok_t         tok_in,
  output pcr_tok_t         tok_out
);

  logic [COLOR_W-1:0] key_r;
  pcr_tok_t           tok_r;
  pcr_tok_t           tok_nxt;
  logic               key_vld;
  logic               hit;

  assign key_vld = {1'b0, cell_idx} < key_count;
  assign hit     = tok_in.vld && key_vld && (key_r == tok_in.color);

  always_comb begin
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.idx   = cell_idx;
      tok_nxt.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kwr.we && (kwr.addr == cell_idx)) begin
      key_r <= kwr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- sv/palette_color_remap.sv -----
// palette colour remapper
// in_if  : requests of func, table_restart, color (valid/ready). a key or
//          palette load appends the colour to that table, restart empties it
//          first, loads into a full table are dropped. a remap request
//          compares the colour with every loaded key and yields one result.
// out_if : one result per remap request: out_color, match_index, no_match,
//          palette_miss (valid/ready). loads and unused codes give none.
// path:   a remap request walks a row of ENTRIES key cells, one register
//          per cell, then passes the palette ram read register and the
//          output register.
// throughput: one remap request per cycle while out_if is not stalled. a
//          load waits until the key cells hold no remap request, since the
//          row of cells must see a fixed key table.
// reset: both tables read as empty, nothing in flight, out_if.valid low.
// stall: while out_if.ready is low with a result waiting, the cells, the
//          ram read stage and the input all hold; nothing is dropped.
module palette_color_remap import pcr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  pcr_in_if.sink         in_if,
  pcr_out_if.source      out_if
);

  logic [CNT_W-1:0]   key_count_r, key_count_nxt;
  logic [CNT_W-1:0]   pal_count_r, pal_count_nxt;
  logic [CNT_W-1:0]   tok_cnt_r, tok_cnt_nxt;

  logic               adv;
  logic               chain_empty;
  logic               in_acc;
  logic               ld_key;
  logic               ld_pal;
  logic               px;
  logic               key_full;
  logic               pal_full;
  logic               pal_we;
  logic [IDX_W-1:0]   pal_waddr;
  logic               leave;

  pcr_kwr_t           kwr;
  pcr_tok_t           chain [ENTRIES+1];
  pcr_tok_t           exit_tok;

  logic               rd_v_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_found_r;
  logic               rd_miss_r;
  logic [COLOR_W-1:0] ram_q;

  logic               out_v_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [MATCH_W-1:0] out_idx_r;
  logic               out_nm_r;
  logic               out_pm_r;

  assign adv         = !out_v_r || out_if.ready;
  assign chain_empty = (tok_cnt_r == '0);
  assign in_if.ready = adv && ((in_if.func == FN_REMAP) || chain_empty);
  assign in_acc      = in_if.valid && in_if.ready;
  assign ld_key      = in_acc && (in_if.func == FN_LOAD_KEY);
  assign ld_pal      = in_acc && (in_if.func == FN_LOAD_PAL);
  assign px          = in_acc && (in_if.func == FN_REMAP);
  assign key_full    = (key_count_r == CNT_W'(ENTRIES));
  assign pal_full    = (pal_count_r == CNT_W'(ENTRIES));

  // table appends
  assign kwr.we    = ld_key && (in_if.table_restart || !key_full);
  assign kwr.addr  = in_if.table_restart ? '0 : key_count_r[IDX_W-1:0];
  assign kwr.data  = in_if.color;
  assign pal_we    = ld_pal && (in_if.table_restart || !pal_full);
  assign pal_waddr = in_if.table_restart ? '0 : pal_count_r[IDX_W-1:0];

  always_comb begin
    key_count_nxt = key_count_r;
    if (ld_key) begin
      if (in_if.table_restart) begin
        key_count_nxt = CNT_W'(1);
      end else if (!key_full) begin
        key_count_nxt = key_count_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    pal_count_nxt = pal_count_r;
    if (ld_pal) begin
      if (in_if.table_restart) begin
        pal_count_nxt = CNT_W'(1);
      end else if (!pal_full) begin
        pal_count_nxt = pal_count_r + CNT_W'(1);
      end
    end
  end

  // row of key cells
  always_comb begin
    chain[0].vld   = px;
    chain[0].color = in_if.color;
    chain[0].idx   = '0;
    chain[0].found = 1'b0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pcr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cell_idx  (IDX_W'(g)),
      .key_count (key_count_r),
      .kwr       (kwr),
      .tok_in    (chain[g]),
      .tok_out   (chain[g+1])
    );
  end

  assign exit_tok = chain[ENTRIES];
  assign leave    = adv && exit_tok.vld;

  always_comb begin
    tok_cnt_nxt = tok_cnt_r;
    case ({px, leave})
      2'b10:   tok_cnt_nxt = tok_cnt_r + CNT_W'(1);
      2'b01:   tok_cnt_nxt = tok_cnt_r - CNT_W'(1);
      default: tok_cnt_nxt = tok_cnt_r;
    endcase
  end

  pcr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (ENTRIES)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (in_if.color),
    .re    (leave),
    .raddr (exit_tok.idx),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      pal_count_r <= '0;
      tok_cnt_r   <= '0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      key_count_r <= key_count_nxt;
      pal_count_r <= pal_count_nxt;
      tok_cnt_r   <= tok_cnt_nxt;
      if (adv) begin
        rd_v_r  <= exit_tok.vld;
        out_v_r <= rd_v_r;
      end
    end
  end

  // palette read stage and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_idx_r    <= exit_tok.idx;
      rd_found_r  <= exit_tok.found;
      rd_miss_r   <= !({1'b0, exit_tok.idx} < pal_count_r);
      out_color_r <= rd_miss_r ? '0 : ram_q;
      out_idx_r   <= match_bits(rd_idx_r);
      out_nm_r    <= !rd_found_r;
      out_pm_r    <= rd_miss_r;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.out_color    = out_color_r;
  assign out_if.match_index  = out_idx_r;
  assign out_if.no_match     = out_nm_r;
  assign out_if.palette_miss = out_pm_r;

  a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_key || ld_pal) |-> chain_empty)
    else $error("table load while remap requests in flight");

  a_count_tracks_exit: assert property (@(posedge clk) disable iff (!rst_n)
    exit_tok.vld |-> !chain_empty)
    else $error("request left the cells without being counted");

  a_key_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= CNT_W'(ENTRIES))
    else $error("key count beyond capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_pm_r) |-> (out_color_r == '0))
    else $error("palette miss with non-zero colour");

  a_nomatch_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_nm_r) |-> (out_idx_r == '0))
    else $error("no match with non-zero index");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import pcr_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int MAX_WAIT     = 7;
  localparam int DRAIN_CYCLES = ENTRIES + 16;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int N_ITEMS      = 2000;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [MATCH_W-1:0] idx;
    logic               no_match;
    logic               palette_miss;
  } remap_res_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               restart;
    logic [COLOR_W-1:0] color;
    logic               typed;
    remap_res_t         res;
  } dir_row_t;

  // typed result only where it is obvious, otherwise the lookup below decides
  localparam dir_row_t DIRECTED [23] = '{
    '{FN_REMAP,    1'b0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 8'd0, 1'b1, 1'b1}},
    '{FN_REMAP,    1'b0, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 8'd0, 1'b1, 1'b1}},
    '{FN_UNUSED,   1'b0, 32'h1234_5678, 1'b0, '0},
    '{FN_LOAD_PAL, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{FN_REMAP,    1'b0, 32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0}},
    '{FN_LOAD_KEY, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},
    '{FN_LOAD_KEY, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{FN_LOAD_KEY, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{FN_REMAP,    1'b0, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 8'd2, 1'b0, 1'b1}},
    '{FN_REMAP,    1'b0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 8'd1, 1'b0, 1'b1}},
    '{FN_LOAD_PAL, 1'b0, 32'h0000_0000, 1'b0, '0},
    '{FN_LOAD_PAL, 1'b0, 32'hA5A5_A5A5, 1'b0, '0},
    '{FN_REMAP,    1'b0, 32'hFFFF_FFFF, 1'b1, '{32'hA5A5_A5A5, 8'd2, 1'b0, 1'b0}},
    '{FN_REMAP,    1'b0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 8'd1, 1'b0, 1'b0}},
    '{FN_REMAP,    1'b0, 32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0}},
    '{FN_REMAP,    1'b1, 32'hFFFF_FFFF, 1'b1, '{32'hA5A5_A5A5, 8'd2, 1'b0, 1'b0}},
    '{FN_UNUSED,   1'b1, 32'hFFFF_FFFF, 1'b0, '0},
    '{FN_LOAD_PAL, 1'b1, 32'h5A5A_5A5A, 1'b0, '0},
    '{FN_REMAP,    1'b0, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 8'd2, 1'b0, 1'b1}},
    '{FN_REMAP,    1'b0, 32'hDEAD_BEEF, 1'b0, '0},
    '{FN_LOAD_KEY, 1'b1, 32'hDEAD_BEEF, 1'b0, '0},
    '{FN_REMAP,    1'b0, 32'hFFFF_FFFF, 1'b0, '0},
    '{FN_REMAP,    1'b0, 32'hDEAD_BEEF, 1'b0, '0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pcr_in_if  in_if ();
  pcr_out_if out_if ();

  palette_color_remap i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [COLOR_W-1:0] key_tab [ENTRIES];
  logic [COLOR_W-1:0] pal_tab [ENTRIES];
  int                 key_cnt;
  int                 pal_cnt;
  remap_res_t         remap_q [$];
  int                 errors;
  int                 n_sent;
  bit                 no_idle;

  function automatic remap_res_t remap_lookup(input logic [COLOR_W-1:0] color);
    remap_res_t r;
    int         hit;
    bit         found;
    hit   = 0;
    found = 1'b0;
    for (int j = 0; j < key_cnt; j++) begin
      if (key_tab[j] == color) begin
        hit   = j;
        found = 1'b1;
      end
    end
    r.idx          = hit[MATCH_W-1:0];
    r.no_match     = !found;
    r.palette_miss = (hit >= pal_cnt);
    r.color        = r.palette_miss ? '0 : pal_tab[hit];
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    logic [7:0] b;
    b = 8'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return {4{b}};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input logic [FUNC_W-1:0] func, input logic restart,
                          input logic [COLOR_W-1:0] color, input logic typed = 1'b0,
                          input remap_res_t typed_res = '0);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      in_if.color <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= func;
    in_if.table_restart <= restart;
    in_if.color         <= color;
    do @(posedge clk); while (!in_if.ready);
    case (func)
      FN_LOAD_KEY: begin
        if (restart) key_cnt = 0;
        if (key_cnt < ENTRIES) begin
          key_tab[key_cnt] = color;
          key_cnt++;
        end
      end
      FN_LOAD_PAL: begin
        if (restart) pal_cnt = 0;
        if (pal_cnt < ENTRIES) begin
          pal_tab[pal_cnt] = color;
          pal_cnt++;
        end
      end
      FN_REMAP: remap_q = {remap_q, (typed ? typed_res : remap_lookup(color))};
      default: ;
    endcase
    if (func != FN_UNUSED) n_sent++;
  endtask

  // result side back-pressure
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk) begin
    remap_res_t got;
    remap_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_color, out_if.match_index, out_if.no_match, out_if.palette_miss};
      if (remap_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: color %h idx %0d no_match %b miss %b",
                   got.color, got.idx, got.no_match, got.palette_miss);
      end else begin
        want = remap_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                     want.color, want.idx, want.no_match, want.palette_miss,
                     got.color, got.idx, got.no_match, got.palette_miss);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** palette_color_remap: FAILED **");
    $finish;
  end

  initial begin
    int   phase;
    int   nk;
    int   np;
    int   nr;
    bit   full_keys;
    bit   full_pal;
    bit   append;
    logic [COLOR_W-1:0] c;
    in_if.valid         <= 1'b0;
    in_if.func          <= FN_LOAD_KEY;
    in_if.table_restart <= 1'b0;
    in_if.color         <= '0;
    key_cnt = 0;
    pal_cnt = 0;
    errors  = 0;
    n_sent  = 0;
    no_idle = 1'b0;
    phase   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_req(DIRECTED[i].func, DIRECTED[i].restart, DIRECTED[i].color,
               DIRECTED[i].typed, DIRECTED[i].res);

    while (n_sent < N_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase > 2 && $urandom_range(0, 7) == 0) begin
        // loose mix of requests
        repeat (30) send_req(FUNC_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                             pick_color());
      end else begin
        full_keys = (phase == 1) || ($urandom_range(0, 15) == 0);
        full_pal  = (phase == 1) || (phase == 2) || ($urandom_range(0, 15) == 0);
        nk        = full_keys ? ENTRIES + $urandom_range(1, 3) : $urandom_range(1, 12);
        np        = full_pal ? ENTRIES + $urandom_range(1, 3) : $urandom_range(0, nk + 2);
        append    = !full_keys && ($urandom_range(0, 3) == 0);
        for (int i = 0; i < nk; i++)
          send_req(FN_LOAD_KEY, (i == 0) && !append, full_keys ? $urandom : pick_color());
        for (int i = 0; i < np; i++)
          send_req(FN_LOAD_PAL, (i == 0) && !append, pick_color());
        nr = $urandom_range(20, 100);
        repeat (nr) begin
          if ($urandom_range(0, 31) == 0)
            send_req(FN_UNUSED, 1'($urandom_range(0, 1)), pick_color());
          c = (key_cnt > 0 && $urandom_range(0, 3) != 0) ?
              key_tab[$urandom_range(0, key_cnt - 1)] : pick_color();
          send_req(FN_REMAP, 1'($urandom_range(0, 1)), c);
        end
      end
      phase++;
    end
    in_if.valid <= 1'b0;

    while (remap_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += remap_q.size();
    if (errors == 0)
      $display("** palette_color_remap: PASSED **");
    else
      $display("** palette_color_remap: FAILED **");
    $finish;
  end

endmodule
